// ===== rtl/cbss_pkg.sv =====
// ----------------------------------------------------------------------------
// cbss_pkg
// shared constants and types of the column boxcar signal select unit
// ----------------------------------------------------------------------------
`default_nettype none

package cbss_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int MAX_HALF_DEF   = 31;
    localparam int MAX_DIM        = 4096;

    localparam int DIM_W      = 12;
    localparam int CFG_DIM_W  = 13;
    localparam int HALF_W     = 5;
    localparam int NOISE_W    = 20;
    localparam int LIMIT_W    = 25;
    localparam int LIMIT_MAX  = 1 << 24;
    localparam int COUNT_W    = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 25;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_DIM_W-1:0] COLUMNS_RST = CFG_DIM_W'(4096);
    localparam logic [CFG_DIM_W-1:0] ROWS_RST    = CFG_DIM_W'(4096);
    localparam logic [HALF_W-1:0]    HALF_RST    = HALF_W'(12);
    localparam logic [NOISE_W-1:0]   NOISE_RST   = NOISE_W'(16);
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = LIMIT_W'(16777216);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COLUMNS = 3'd0,
        REG_ROWS    = 3'd1,
        REG_HALF    = 3'd2,
        REG_NOISE   = 3'd3,
        REG_LIMIT   = 3'd4,
        REG_MASK    = 3'd5
    } cfg_reg_t;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [CFG_DIM_W-1:0] columns;
        logic [CFG_DIM_W-1:0] rows;
        logic [HALF_W-1:0]    half;
        logic [NOISE_W-1:0]   noise;
        logic [LIMIT_W-1:0]   limit;
        logic                 mask_en;
    } cfg_t;

    // classified pixel between front and back
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] column;
        logic             col_end;
        logic             img_end;
        logic             good;
    } qctl_t;

    // one back-end operation
    typedef struct packed {
        logic             valid;
        logic             decide;
        logic             select;
        logic             good;
        logic             done;
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] column;
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/cbss_front.sv =====
// ----------------------------------------------------------------------------
// cbss_front
// accepts pixels, tracks row and column, flags column and image end
// ----------------------------------------------------------------------------
`default_nettype none

module cbss_front #(
    parameter int PIXEL_BITS = cbss_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cbss_pkg::cfg_t               cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [PIXEL_BITS-1:0] s_pixel_value,
    input  wire logic                         s_pixel_good,
    input  wire logic                         q_full,
    output logic                              push,
    output logic signed [PIXEL_BITS-1:0]      push_pixel,
    output cbss_pkg::qctl_t                   push_ctl
);

    logic [cbss_pkg::DIM_W-1:0] row_reg, row_next;
    logic [cbss_pkg::DIM_W-1:0] column_reg, column_next;
    logic                       accept;
    logic                       col_end;
    logic                       img_end;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    assign col_end = ({1'b0, row_reg} + cbss_pkg::CFG_DIM_W'(1)) >= cfg.rows;
    assign img_end = col_end
                     && (({1'b0, column_reg} + cbss_pkg::CFG_DIM_W'(1)) >= cfg.columns);

    always_comb begin
        row_next    = row_reg;
        column_next = column_reg;
        if (accept) begin
            if (col_end) begin
                row_next = '0;
                if (img_end) begin
                    column_next = '0;
                end else begin
                    column_next = column_reg + cbss_pkg::DIM_W'(1);
                end
            end else begin
                row_next = row_reg + cbss_pkg::DIM_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            column_reg <= '0;
        end else begin
            row_reg    <= row_next;
            column_reg <= column_next;
        end
    end

    assign push             = accept;
    assign push_pixel       = s_pixel_value;
    assign push_ctl.row     = row_reg;
    assign push_ctl.column  = column_reg;
    assign push_ctl.col_end = col_end;
    assign push_ctl.img_end = img_end;
    assign push_ctl.good    = s_pixel_good;

endmodule

`default_nettype wire

// ===== rtl/cbss_queue.sv =====
// ----------------------------------------------------------------------------
// cbss_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cbss_queue #(
    parameter int PIXEL_BITS = cbss_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire logic signed [PIXEL_BITS-1:0] push_pixel,
    input  wire cbss_pkg::qctl_t              push_ctl,
    output logic                              full,
    input  wire logic                         pop,
    output logic                              empty,
    output logic signed [PIXEL_BITS-1:0]      head_pixel,
    output cbss_pkg::qctl_t                   head_ctl
);

    localparam int DEPTH = cbss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [PIXEL_BITS-1:0] pix_q [DEPTH];
    cbss_pkg::qctl_t              ctl_q [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full    = fill_reg == CNT_W'(DEPTH);
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            pix_q[wr_ptr_reg] <= push_pixel;
            ctl_q[wr_ptr_reg] <= push_ctl;
        end
    end

    assign head_pixel = pix_q[rd_ptr_reg];
    assign head_ctl   = ctl_q[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/cbss_back.sv =====
// ----------------------------------------------------------------------------
// cbss_back
// row sequencer, delay ring, running window and threshold test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module cbss_back #(
    parameter int PIXEL_BITS = cbss_pkg::PIXEL_BITS_DEF,
    parameter int MAX_HALF   = cbss_pkg::MAX_HALF_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cbss_pkg::cfg_t               cfg,
    input  wire logic                         q_empty,
    input  wire logic signed [PIXEL_BITS-1:0] q_pixel,
    input  wire cbss_pkg::qctl_t              q_ctl,
    output logic                              q_pop,
    input  wire logic                         adv,
    output cbss_pkg::op_t                     op_out
);

    localparam int RING_DEPTH = 2 * MAX_HALF + 1;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int AMT_W      = cbss_pkg::HALF_W + 1;
    localparam int WRAP_W     = ((SLOT_W > AMT_W) ? SLOT_W : AMT_W) + 1;
    localparam int SUM_W      = PIXEL_BITS + 6;
    localparam int SUM16_W    = SUM_W + 4;
    localparam int DIFF_W     = ((PIXEL_BITS + 4 > cbss_pkg::NOISE_W) ?
                                 PIXEL_BITS + 4 : cbss_pkg::NOISE_W) + 1;
    localparam int PROD_W     = DIFF_W + cbss_pkg::COUNT_W + 1;
    localparam int CMP_W      = (PROD_W > SUM16_W) ? PROD_W : SUM16_W;
    localparam int DIM_W      = cbss_pkg::DIM_W;
    localparam int COUNT_W    = cbss_pkg::COUNT_W;

    typedef enum logic [1:0] {
        SEQ_PIXEL,
        SEQ_DRAIN,
        SEQ_DONE
    } seq_state_t;

    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
                                                    input logic [AMT_W-1:0]  amt);
        logic [WRAP_W-1:0] s;
        logic [WRAP_W-1:0] a;
        s = WRAP_W'(slot);
        a = WRAP_W'(amt);
        if (s >= a) begin
            slot_back = SLOT_W'(s - a);
        end else begin
            slot_back = SLOT_W'(s + WRAP_W'(RING_DEPTH) - a);
        end
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        if (slot == SLOT_W'(RING_DEPTH - 1)) begin
            slot_inc = '0;
        end else begin
            slot_inc = slot + SLOT_W'(1);
        end
    endfunction

    // sequencer
    seq_state_t        seq_state_reg, seq_state_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [DIM_W-1:0]  drain_row_reg, drain_row_next;
    logic [SLOT_W-1:0] drain_slot_reg, drain_slot_next;
    logic [DIM_W-1:0]  drain_end_reg, drain_end_next;
    logic [DIM_W-1:0]  drain_col_reg, drain_col_next;
    logic              drain_img_reg, drain_img_next;

    logic [DIM_W-1:0]  half_dim;
    logic [AMT_W-1:0]  half_amt;
    logic [AMT_W-1:0]  twice_amt;
    logic              t_ge_h;
    logic [DIM_W-1:0]  pix_d;
    logic              pix_d_ge_h;
    logic [SLOT_W-1:0] pix_dec_slot;

    cbss_pkg::op_t     a_op;
    logic              a_add;
    logic              a_drop;
    logic              a_clear;
    logic              a_wr;
    logic [SLOT_W-1:0] dec_slot;
    logic [SLOT_W-1:0] drop_slot;

    // ring of recent pixels with good bit on top
    logic [PIXEL_BITS:0]          ring_mem [RING_DEPTH];
    logic [PIXEL_BITS:0]          dec_rd_reg;
    logic signed [PIXEL_BITS-1:0] drop_rd_reg;

    // stage 1
    cbss_pkg::op_t                s1_op_reg;
    logic                         s1_add_reg;
    logic                         s1_drop_reg;
    logic                         s1_clear_reg;
    logic signed [PIXEL_BITS-1:0] s1_pixel_reg;
    cbss_pkg::op_t                s1_op_fwd;

    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]      add_term;
    logic signed [SUM_W-1:0]      drop_term;
    logic signed [SUM_W-1:0]      sum_dec;
    logic [COUNT_W-1:0]           count_dec;
    logic signed [PIXEL_BITS-1:0] dec_pixel;
    logic signed [DIFF_W-1:0]     diff;

    // stage 2
    cbss_pkg::op_t                s2_op_reg;
    logic signed [DIFF_W-1:0]     s2_diff_reg;
    logic [COUNT_W-1:0]           s2_count_reg;
    logic signed [SUM16_W-1:0]    s2_sum16_reg;

    // stage 3
    cbss_pkg::op_t                s3_op_reg;
    logic signed [PROD_W-1:0]     s3_prod_reg;
    logic signed [SUM16_W-1:0]    s3_sum16_reg;
    cbss_pkg::op_t                s3_op_fwd;

    // stage 4
    cbss_pkg::op_t                s4_op_reg;

    assign half_dim     = DIM_W'(cfg.half);
    assign half_amt     = AMT_W'(cfg.half);
    assign twice_amt    = {cfg.half, 1'b0};
    assign t_ge_h       = q_ctl.row >= half_dim;
    assign pix_d        = q_ctl.row - half_dim;
    assign pix_d_ge_h   = pix_d >= half_dim;
    assign pix_dec_slot = slot_back(wslot_reg, half_amt);

    always_comb begin
        seq_state_next  = seq_state_reg;
        wslot_next      = wslot_reg;
        drain_row_next  = drain_row_reg;
        drain_slot_next = drain_slot_reg;
        drain_end_next  = drain_end_reg;
        drain_col_next  = drain_col_reg;
        drain_img_next  = drain_img_reg;
        a_op            = '0;
        a_add           = 1'b0;
        a_drop          = 1'b0;
        a_clear         = 1'b0;
        a_wr            = 1'b0;
        dec_slot        = pix_dec_slot;
        drop_slot       = slot_back(wslot_reg, twice_amt);
        q_pop           = 1'b0;
        case (seq_state_reg)
            SEQ_PIXEL: begin
                if (!q_empty) begin
                    a_op.valid  = 1'b1;
                    a_op.decide = t_ge_h;
                    a_op.last   = !q_ctl.col_end;
                    a_op.row    = pix_d;
                    a_op.column = q_ctl.column;
                    a_add       = 1'b1;
                    a_wr        = 1'b1;
                    a_drop      = t_ge_h && pix_d_ge_h;
                    if (adv) begin
                        q_pop = 1'b1;
                        if (q_ctl.col_end) begin
                            seq_state_next  = SEQ_DRAIN;
                            wslot_next      = '0;
                            drain_row_next  = t_ge_h ? pix_d + DIM_W'(1) : '0;
                            drain_slot_next = t_ge_h ? slot_inc(pix_dec_slot) : '0;
                            drain_end_next  = q_ctl.row;
                            drain_col_next  = q_ctl.column;
                            drain_img_next  = q_ctl.img_end;
                        end else begin
                            wslot_next = slot_inc(wslot_reg);
                        end
                    end
                end
            end
            SEQ_DRAIN: begin
                a_op.valid  = 1'b1;
                a_op.decide = 1'b1;
                a_op.last   = (drain_row_reg == drain_end_reg) && !drain_img_reg;
                a_op.row    = drain_row_reg;
                a_op.column = drain_col_reg;
                a_drop      = drain_row_reg >= half_dim;
                a_clear     = drain_row_reg == drain_end_reg;
                dec_slot    = drain_slot_reg;
                drop_slot   = slot_back(drain_slot_reg, half_amt);
                if (adv) begin
                    if (drain_row_reg == drain_end_reg) begin
                        seq_state_next = drain_img_reg ? SEQ_DONE : SEQ_PIXEL;
                    end else begin
                        drain_row_next  = drain_row_reg + DIM_W'(1);
                        drain_slot_next = slot_inc(drain_slot_reg);
                    end
                end
            end
            SEQ_DONE: begin
                a_op.valid = 1'b1;
                a_op.done  = 1'b1;
                a_op.last  = 1'b1;
                if (adv) begin
                    seq_state_next = SEQ_PIXEL;
                end
            end
            default: begin
                seq_state_next = SEQ_PIXEL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_state_reg  <= SEQ_PIXEL;
            wslot_reg      <= '0;
            drain_row_reg  <= '0;
            drain_slot_reg <= '0;
            drain_end_reg  <= '0;
            drain_col_reg  <= '0;
            drain_img_reg  <= 1'b0;
        end else begin
            seq_state_reg  <= seq_state_next;
            wslot_reg      <= wslot_next;
            drain_row_reg  <= drain_row_next;
            drain_slot_reg <= drain_slot_next;
            drain_end_reg  <= drain_end_next;
            drain_col_reg  <= drain_col_next;
            drain_img_reg  <= drain_img_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (a_wr) begin
                ring_mem[wslot_reg] <= {q_ctl.good, q_pixel};
            end
            dec_rd_reg  <= ring_mem[dec_slot];
            drop_rd_reg <= ring_mem[drop_slot][PIXEL_BITS-1:0];
        end
    end

    // stage 1: window update and margin
    assign add_term  = s1_add_reg ? SUM_W'(s1_pixel_reg) : '0;
    assign drop_term = s1_drop_reg ? SUM_W'(drop_rd_reg) : '0;
    assign sum_dec   = sum_reg + add_term - drop_term;
    assign count_dec = count_reg + COUNT_W'(s1_add_reg) - COUNT_W'(s1_drop_reg);
    assign dec_pixel = dec_rd_reg[PIXEL_BITS-1:0];
    assign diff      = (DIFF_W'(dec_pixel) <<< 4) - DIFF_W'($signed(cfg.noise));

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (adv && s1_op_reg.valid) begin
            sum_next   = s1_clear_reg ? '0 : sum_dec;
            count_next = s1_clear_reg ? '0 : count_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // operations with the good bit and the test outcome filled in
    always_comb begin
        s1_op_fwd        = s1_op_reg;
        s1_op_fwd.good   = dec_rd_reg[PIXEL_BITS];
        s3_op_fwd        = s3_op_reg;
        s3_op_fwd.select = CMP_W'(s3_prod_reg) > CMP_W'(s3_sum16_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_op_reg.valid <= 1'b0;
            s2_op_reg.valid <= 1'b0;
            s3_op_reg.valid <= 1'b0;
            s4_op_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_op_reg          <= a_op;
            s1_add_reg         <= a_add;
            s1_drop_reg        <= a_drop;
            s1_clear_reg       <= a_clear;
            s1_pixel_reg       <= q_pixel;

            s2_op_reg          <= s1_op_fwd;
            s2_diff_reg        <= diff;
            s2_count_reg       <= count_dec;
            s2_sum16_reg       <= $signed({sum_dec, 4'b0000});

            s3_op_reg          <= s2_op_reg;
            s3_prod_reg        <= PROD_W'(s2_diff_reg)
                                  * PROD_W'($signed({1'b0, s2_count_reg}));
            s3_sum16_reg       <= s2_sum16_reg;

            s4_op_reg          <= s3_op_fwd;
        end
    end

    assign op_out = s4_op_reg;

endmodule

`default_nettype wire

// ===== rtl/cbss_emit.sv =====
// ----------------------------------------------------------------------------
// cbss_emit
// hit counting, overflow and done results, last flag and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cbss_emit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire cbss_pkg::cfg_t                   cfg,
    input  wire cbss_pkg::op_t                    op,
    output logic                                  adv,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [cbss_pkg::DIM_W-1:0]            m_hit_column,
    output logic [cbss_pkg::DIM_W-1:0]            m_hit_row,
    output logic                                  m_overflow,
    output logic                                  m_image_done,
    output logic [cbss_pkg::LIMIT_W-1:0]          m_hit_total,
    output logic                                  m_run_last
);

    typedef struct packed {
        logic [cbss_pkg::DIM_W-1:0]   column;
        logic [cbss_pkg::DIM_W-1:0]   row;
        logic                         overflow;
        logic                         image_done;
        logic [cbss_pkg::LIMIT_W-1:0] total;
    } res_t;

    logic [cbss_pkg::LIMIT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic                         ovf_seen_reg, ovf_seen_next;
    res_t                         hold_reg, hold_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic                         hold_final_reg, hold_final_next;
    res_t                         out_reg, out_next;
    logic                         out_last_reg, out_last_next;
    logic                         m_valid_reg, m_valid_next;

    logic out_free;
    logic flush;
    logic take;
    logic sel;
    res_t res;
    logic res_valid;
    logic load_out;

    assign out_free = !m_valid_reg || m_ready;
    assign flush    = hold_valid_reg && hold_final_reg;
    assign adv      = out_free && !flush;
    assign take     = adv && op.valid;
    assign sel      = op.decide && op.select && (!cfg.mask_en || op.good);

    // result of the current operation
    always_comb begin
        res           = '0;
        res_valid     = 1'b0;
        hit_cnt_next  = hit_cnt_reg;
        ovf_seen_next = ovf_seen_reg;
        if (take) begin
            if (sel && !ovf_seen_reg) begin
                res_valid  = 1'b1;
                res.column = op.column;
                res.row    = op.row;
                if (hit_cnt_reg >= cfg.limit) begin
                    res.overflow  = 1'b1;
                    ovf_seen_next = 1'b1;
                end else begin
                    hit_cnt_next = hit_cnt_reg + cbss_pkg::LIMIT_W'(1);
                end
            end
            if (op.done) begin
                if (!ovf_seen_reg) begin
                    res_valid      = 1'b1;
                    res.image_done = 1'b1;
                    res.total      = hit_cnt_reg;
                end
                hit_cnt_next  = '0;
                ovf_seen_next = 1'b0;
            end
        end
    end

    // one result held back until the next one or the end of the transaction
    always_comb begin
        load_out        = 1'b0;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        if (flush) begin
            if (out_free) begin
                load_out        = 1'b1;
                out_next        = hold_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
                hold_final_next = 1'b0;
            end
        end else if (take) begin
            if (res_valid && hold_valid_reg) begin
                load_out        = 1'b1;
                out_next        = hold_reg;
                out_last_next   = 1'b0;
                hold_next       = res;
                hold_final_next = op.last;
            end else if (res_valid) begin
                if (op.last) begin
                    load_out      = 1'b1;
                    out_next      = res;
                    out_last_next = 1'b1;
                end else begin
                    hold_valid_next = 1'b1;
                    hold_final_next = 1'b0;
                    hold_next       = res;
                end
            end else if (hold_valid_reg && op.last) begin
                load_out        = 1'b1;
                out_next        = hold_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg    <= '0;
            ovf_seen_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hit_cnt_reg    <= hit_cnt_next;
            ovf_seen_reg   <= ovf_seen_next;
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hit_column = out_reg.column;
    assign m_hit_row    = out_reg.row;
    assign m_overflow   = out_reg.overflow;
    assign m_image_done = out_reg.image_done;
    assign m_hit_total  = out_reg.total;
    assign m_run_last   = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/column_boxcar_signal_select_unit.sv =====
// ----------------------------------------------------------------------------
// column_boxcar_signal_select_unit
// running-mean threshold detector over image columns in column-major order
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    pixel_value, pixel_good
//   m_        out        m_valid / m_ready    hit_column, hit_row, overflow,
//                                             image_done, hit_total, run_last
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// one pixel per cycle while results are taken; at each column end the row sequencer
// drains the last min(window_half, image_rows) rows without taking pixels, and it
// adds a done operation at image end
// a transaction whose last result follows a held result stalls while that one is flushed
// synchronous active-low reset, no clearing pass; the ring is written before read
// a low m_ready while a result waits freezes the back pipeline; a four-entry queue buffers the input
// ----------------------------------------------------------------------------
`default_nettype none

module column_boxcar_signal_select_unit #(
    parameter int PIXEL_BITS = cbss_pkg::PIXEL_BITS_DEF,
    parameter int MAX_HALF   = cbss_pkg::MAX_HALF_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cbss_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  wire logic [cbss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [PIXEL_BITS-1:0]        s_pixel_value,
    input  wire logic                                s_pixel_good,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cbss_pkg::DIM_W-1:0]               m_hit_column,
    output logic [cbss_pkg::DIM_W-1:0]               m_hit_row,
    output logic                                     m_overflow,
    output logic                                     m_image_done,
    output logic [cbss_pkg::LIMIT_W-1:0]             m_hit_total,
    output logic                                     m_run_last
);

    localparam int CD_W = cbss_pkg::CFG_DIM_W;
    localparam int HW   = cbss_pkg::HALF_W;
    localparam int LW   = cbss_pkg::LIMIT_W;

    logic [CD_W-1:0]              columns_reg;
    logic [CD_W-1:0]              rows_reg;
    logic [HW-1:0]                half_reg;
    logic [cbss_pkg::NOISE_W-1:0] noise_reg;
    logic [LW-1:0]                limit_reg;
    logic                         mask_reg;

    cbss_pkg::cfg_t               cfg;

    logic                         push;
    logic signed [PIXEL_BITS-1:0] push_pixel;
    cbss_pkg::qctl_t              push_ctl;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    logic signed [PIXEL_BITS-1:0] q_pixel;
    cbss_pkg::qctl_t              q_ctl;
    logic                         adv;
    cbss_pkg::op_t                op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= cbss_pkg::COLUMNS_RST;
            rows_reg    <= cbss_pkg::ROWS_RST;
            half_reg    <= cbss_pkg::HALF_RST;
            noise_reg   <= cbss_pkg::NOISE_RST;
            limit_reg   <= cbss_pkg::LIMIT_RST;
            mask_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cbss_pkg::REG_COLUMNS: columns_reg <= cfg_wdata[CD_W-1:0];
                cbss_pkg::REG_ROWS:    rows_reg    <= cfg_wdata[CD_W-1:0];
                cbss_pkg::REG_HALF:    half_reg    <= cfg_wdata[HW-1:0];
                cbss_pkg::REG_NOISE:   noise_reg   <= cfg_wdata[cbss_pkg::NOISE_W-1:0];
                cbss_pkg::REG_LIMIT:   limit_reg   <= cfg_wdata[LW-1:0];
                cbss_pkg::REG_MASK:    mask_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // clamp to the legal ranges
    always_comb begin
        cfg.columns = (columns_reg == '0) ? CD_W'(1) :
                      (columns_reg > CD_W'(cbss_pkg::MAX_DIM)) ? CD_W'(cbss_pkg::MAX_DIM) :
                      columns_reg;
        cfg.rows    = (rows_reg == '0) ? CD_W'(1) :
                      (rows_reg > CD_W'(cbss_pkg::MAX_DIM)) ? CD_W'(cbss_pkg::MAX_DIM) :
                      rows_reg;
        cfg.half    = (half_reg == '0) ? HW'(1) :
                      (half_reg > HW'(MAX_HALF)) ? HW'(MAX_HALF) : half_reg;
        cfg.noise   = noise_reg;
        cfg.limit   = (limit_reg > LW'(cbss_pkg::LIMIT_MAX)) ? LW'(cbss_pkg::LIMIT_MAX) :
                      limit_reg;
        cfg.mask_en = mask_reg;
    end

    cbss_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_pixel_good  (s_pixel_good),
        .q_full        (q_full),
        .push          (push),
        .push_pixel    (push_pixel),
        .push_ctl      (push_ctl)
    );

    cbss_queue #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_pixel (push_pixel),
        .push_ctl   (push_ctl),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_pixel (q_pixel),
        .head_ctl   (q_ctl)
    );

    cbss_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_HALF   (MAX_HALF)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_pixel (q_pixel),
        .q_ctl   (q_ctl),
        .q_pop   (q_pop),
        .adv     (adv),
        .op_out  (op)
    );

    cbss_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .op           (op),
        .adv          (adv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit_column (m_hit_column),
        .m_hit_row    (m_hit_row),
        .m_overflow   (m_overflow),
        .m_image_done (m_image_done),
        .m_hit_total  (m_hit_total),
        .m_run_last   (m_run_last)
    );

endmodule

`default_nettype wire
